>>> rtl/zigzag_scan_address_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the zigzag scan address generator
// Shared property forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef ZIGZAG_SCAN_ADDRESS_GENERATOR_CORE_ASSERT_SVH
`define ZIGZAG_SCAN_ADDRESS_GENERATOR_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ZZSAG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ZZSAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/zzsag_pkg.sv
// ----------------------------------------------------------------------------
// Zigzag scan address generator package
// Direction and wall-position codes, register indexes and the grid size limit.
// ----------------------------------------------------------------------------
package zzsag_pkg;

  localparam int MAX_DIM = 64;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    DIR_DOWN      = 4'd0,
    DIR_RIGHT     = 4'd3,
    DIR_DOWN_LEFT = 4'd4,
    DIR_UP_RIGHT  = 4'd7,
    DIR_NONE      = 4'd8
  } dir_t;

  typedef enum logic [2:0] {
    POS_CENTER = 3'd0,
    POS_LEFT   = 3'd1,
    POS_BOTTOM = 3'd2,
    POS_TOP    = 3'd3,
    POS_RIGHT  = 3'd4,
    POS_OUT    = 3'd5
  } pos_t;

endpackage

>>> rtl/zigzag_scan_address_generator_core.sv
// ----------------------------------------------------------------------------
// Zigzag scan address generator
// Walks a configurable grid in anti-diagonal order, one cell per beat.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+---------------------------------
//  in_     | input     | in_valid/stall   | restart
//  out_    | output    | out_valid/stall  | column, row, order_number, last
//  cfg_    | input     | cfg_we           | cfg_index, cfg_data
//
//  Each input beat produces one output beat on the following cycle, and a
//  new input beat is taken every cycle while the output is not stalled.
//  The scan state and the result register update in the same cycle.
//  A stalled output register holds its beat and stalls the input side.
//  Synchronous reset restores both grid sizes to eight and clears the scan.
//
module zigzag_scan_address_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_column,
  output logic [5:0]  out_row,
  output logic [12:0] out_order_number,
  output logic        out_last_cell,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  function automatic zzsag_pkg::pos_t locate(logic signed [7:0] x, logic signed [7:0] y,
                                             logic [6:0] w, logic [6:0] h);
    logic signed [7:0] ws;
    logic signed [7:0] hs;
    ws = $signed({1'b0, w});
    hs = $signed({1'b0, h});
    if (x < 8'sd0 || y < 8'sd0 || x >= ws || y >= hs) return zzsag_pkg::POS_OUT;
    else if (x == ws - 8'sd1) return zzsag_pkg::POS_RIGHT;
    else if (y == 8'sd0 && x != 8'sd0) return zzsag_pkg::POS_TOP;
    else if (y == hs - 8'sd1) return zzsag_pkg::POS_BOTTOM;
    else if (x == 8'sd0) return zzsag_pkg::POS_LEFT;
    else return zzsag_pkg::POS_CENTER;
  endfunction

  function automatic zzsag_pkg::dir_t along_dir(zzsag_pkg::pos_t p);
    case (p)
      zzsag_pkg::POS_LEFT, zzsag_pkg::POS_RIGHT:  return zzsag_pkg::DIR_DOWN;
      zzsag_pkg::POS_TOP, zzsag_pkg::POS_BOTTOM:  return zzsag_pkg::DIR_RIGHT;
      default:                                    return zzsag_pkg::DIR_NONE;
    endcase
  endfunction

  function automatic zzsag_pkg::dir_t away_dir(zzsag_pkg::pos_t p);
    case (p)
      zzsag_pkg::POS_LEFT, zzsag_pkg::POS_BOTTOM: return zzsag_pkg::DIR_UP_RIGHT;
      zzsag_pkg::POS_TOP, zzsag_pkg::POS_RIGHT:   return zzsag_pkg::DIR_DOWN_LEFT;
      default:                                    return zzsag_pkg::DIR_NONE;
    endcase
  endfunction

  logic [6:0]          grid_width_r;
  logic [6:0]          grid_height_r;
  logic [5:0]          col_r, col_nxt;
  logic [5:0]          row_r, row_nxt;
  zzsag_pkg::dir_t     dir_r, dir_nxt;
  logic [12:0]         count_r, count_nxt;
  logic                last_nxt;
  logic                out_valid_r;
  logic [5:0]          out_column_r;
  logic [5:0]          out_row_r;
  logic [12:0]         out_order_number_r;
  logic                out_last_cell_r;

  logic                in_accept;
  logic [6:0]          w_eff;
  logic [6:0]          h_eff;
  logic [13:0]         total_full;
  logic [12:0]         total;
  logic signed [7:0]   x, y, nx, ny;
  zzsag_pkg::pos_t     pos_cur, pos_up, pos_left, pos_next;
  zzsag_pkg::dir_t     dir_calc;
  logic                came_wall;
  logic                hold;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;

  always_comb begin
    if (grid_width_r == 7'd0) w_eff = 7'd1;
    else if (grid_width_r > 7'(zzsag_pkg::MAX_DIM)) w_eff = 7'(zzsag_pkg::MAX_DIM);
    else w_eff = grid_width_r;
    if (grid_height_r == 7'd0) h_eff = 7'd1;
    else if (grid_height_r > 7'(zzsag_pkg::MAX_DIM)) h_eff = 7'(zzsag_pkg::MAX_DIM);
    else h_eff = grid_height_r;
  end

  assign total_full = w_eff * h_eff;
  assign total      = total_full[12:0];

  assign x        = $signed({2'b00, col_r});
  assign y        = $signed({2'b00, row_r});
  assign pos_cur  = locate(x, y, w_eff, h_eff);
  assign pos_up   = locate(x, y - 8'sd1, w_eff, h_eff);
  assign pos_left = locate(x - 8'sd1, y, w_eff, h_eff);

  always_comb begin
    case (dir_r)
      zzsag_pkg::DIR_DOWN:
        came_wall = (pos_up == zzsag_pkg::POS_LEFT) || (pos_up == zzsag_pkg::POS_RIGHT);
      zzsag_pkg::DIR_RIGHT:
        came_wall = (pos_left == zzsag_pkg::POS_TOP) || (pos_left == zzsag_pkg::POS_BOTTOM);
      default:
        came_wall = 1'b0;
    endcase
  end

  always_comb begin
    if (w_eff == 7'd1) dir_calc = zzsag_pkg::DIR_DOWN;
    else if (h_eff == 7'd1) dir_calc = zzsag_pkg::DIR_RIGHT;
    else if (dir_r == zzsag_pkg::DIR_NONE)
      dir_calc = (pos_cur == zzsag_pkg::POS_CENTER) ? zzsag_pkg::DIR_NONE : along_dir(pos_cur);
    else if (pos_cur == zzsag_pkg::POS_CENTER) dir_calc = dir_r;
    else dir_calc = came_wall ? away_dir(pos_cur) : along_dir(pos_cur);
  end

  always_comb begin
    case (dir_calc)
      zzsag_pkg::DIR_DOWN:      begin nx = x;          ny = y + 8'sd1; end
      zzsag_pkg::DIR_RIGHT:     begin nx = x + 8'sd1;  ny = y;         end
      zzsag_pkg::DIR_DOWN_LEFT: begin nx = x - 8'sd1;  ny = y + 8'sd1; end
      zzsag_pkg::DIR_UP_RIGHT:  begin nx = x + 8'sd1;  ny = y - 8'sd1; end
      default:                  begin nx = x;          ny = y;         end
    endcase
  end

  assign pos_next = locate(nx, ny, w_eff, h_eff);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    dir_nxt   = dir_r;
    count_nxt = count_r;
    hold      = (count_r >= total) || (pos_cur == zzsag_pkg::POS_OUT) ||
                (dir_calc == zzsag_pkg::DIR_NONE) || (pos_next == zzsag_pkg::POS_OUT);
    if (in_restart || count_r == 13'd0) begin
      col_nxt   = 6'd0;
      row_nxt   = 6'd0;
      dir_nxt   = zzsag_pkg::DIR_NONE;
      count_nxt = 13'd1;
      last_nxt  = (total == 13'd1);
    end else begin
      if (!hold) begin
        col_nxt   = nx[5:0];
        row_nxt   = ny[5:0];
        dir_nxt   = dir_calc;
        count_nxt = count_r + 13'd1;
      end
      last_nxt = hold || (count_nxt >= total);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 7'd8;
      grid_height_r <= 7'd8;
      col_r         <= 6'd0;
      row_r         <= 6'd0;
      dir_r         <= zzsag_pkg::DIR_NONE;
      count_r       <= 13'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == zzsag_pkg::REG_GRID_HEIGHT) grid_height_r <= cfg_data;
        else grid_width_r <= cfg_data;
      end
      if (in_accept) begin
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        dir_r       <= dir_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_column_r       <= col_nxt;
      out_row_r          <= row_nxt;
      out_order_number_r <= count_nxt;
      out_last_cell_r    <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column       = out_column_r;
  assign out_row          = out_row_r;
  assign out_order_number = out_order_number_r;
  assign out_last_cell    = out_last_cell_r;

`include "zigzag_scan_address_generator_core_assert.svh"

  `ZZSAG_ASSERT_NOW(a_order_nonzero, clk, rst_n, out_valid_r,
    out_order_number_r != 13'd0, "result beat carries order number zero")
  `ZZSAG_ASSERT_NEXT(a_restart_origin, clk, rst_n, in_accept && in_restart,
    out_column_r == 6'd0 && out_row_r == 6'd0 && out_order_number_r == 13'd1,
    "restart beat did not return to the origin")
  `ZZSAG_ASSERT_NEXT(a_order_step, clk, rst_n, in_accept && !in_restart && count_r != 13'd0,
    out_order_number_r == $past(count_r) || out_order_number_r == $past(count_r) + 13'd1,
    "order number moved by more than one cell")

endmodule
